// ===== rtl/command_frame_parser_core_defines.svh =====
// Assertion macros used by the command frame parser controller
`ifndef COMMAND_FRAME_PARSER_CORE_DEFINES_SVH
`define COMMAND_FRAME_PARSER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cfp_pkg.sv =====
// Types and constants of the command frame parser
`default_nettype none

package cfp_pkg;

	localparam int CMD_BYTES = 1;
	localparam int HDR_W     = 8 * CMD_BYTES;
	localparam int BYTE_W    = 8;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int ENTRY_W   = 15;
	localparam int LEN_LSB   = 8;
	localparam int LEN_W     = 6;
	localparam int VALID_BIT = 14;
	localparam int TICK_W    = 16;
	localparam int IDX_W     = 2;

	localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd100;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_ENTRY_ZERO = 3'd0;
	localparam logic [2:0] REG_TIMEOUT    = 3'd4;

	// input word kinds
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_PAYLOAD = 2'd0,
		ST_DONE    = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_TIMEOUT = 2'd3
	} cfp_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COLLECT,
		S_DRAIN
	} cfp_state_t;

	// controller -> datapath
	typedef struct packed {
		logic        latch_hdr;
		logic        store_byte;
		logic        tick;
		logic        clear;
		logic        rd_issue;
		logic        out_load;
		cfp_status_t out_sel;
	} cfp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic hit;
		logic len_zero;
		logic rx_done;
		logic tmo;
		logic rd_more;
	} cfp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/cfp_in_if.sv =====
// Input channel: one byte or one tick per word
`default_nettype none

interface cfp_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;

	modport source (output valid, output cmd, output data_byte, input ready);
	modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfp_out_if.sv =====
// Result channel of the command frame parser
`default_nettype none

interface cfp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [1:0] entry_index;
	logic [7:0] command_code;
	logic [7:0] payload_byte;
	logic       last;

	modport source (output valid, output status, output entry_index, output command_code,
		output payload_byte, output last, input ready);
	modport sink   (input valid, input status, input entry_index, input command_code,
		input payload_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/command_frame_parser_core.sv =====
// Top level of the table-driven command frame parser
`default_nettype none

// Command frame parser. Input words are either a received byte (cmd = 0) or
// one time tick (cmd = 1). While idle, each byte is a one-byte command header
// and is matched against the command table (APB registers 0..3, byte address
// 4*i: code in bits 7:0, payload length in bits 13:8, valid in bit 14); the
// lowest-numbered valid match wins. No match gives one "unknown" word; a match
// with length zero gives one "done" word. Otherwise the parser collects that
// many payload bytes (length clamped to MAX_ARGS) into a small RAM, then
// drains them in order as payload words, the last one marked. Ticks during
// collection are counted (saturating); once the count exceeds timeout_ticks
// (register 4, reset 100) the frame is dropped and one timeout word is sent.
// Ticks while idle are ignored. Table entry and length are latched when the
// header matches, so table writes during collection only affect the next
// frame; write registers only while the parser is idle.
// Timing: while idle or collecting, one input word is taken per cycle as long
// as the output register is empty or being emptied in that cycle; a done,
// unknown or timeout word shows up on the result channel the cycle after the
// input word that causes it. After the last payload byte the parser drains
// the stored bytes in order: each is read through the registered RAM read
// port and then loaded into the output word register, at one word per cycle
// while the result channel accepts them (the drain stalls when it does not);
// input is held off during the drain.
// Control registers, counters and the output word valid reset asynchronously
// on arst_n low; the output word fields and the payload RAM do not.

module command_frame_parser_core #(
	parameter int TABLE_ENTRIES = 4,
	parameter int MAX_ARGS      = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	cfp_in_if.sink                          item,
	cfp_out_if.source                       result,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cfp_pkg::APB_AW-1:0] paddr,
	input  wire logic [cfp_pkg::APB_DW-1:0] pwdata,
	output logic      [cfp_pkg::APB_DW-1:0] prdata,
	output logic                            pready
);

	logic [TABLE_ENTRIES-1:0][cfp_pkg::ENTRY_W-1:0] entries;
	logic [cfp_pkg::TICK_W-1:0]                     timeout;
	cfp_pkg::cfp_cmd_t                              cmd;
	cfp_pkg::cfp_sts_t                              sts;

	// configuration registers
	cfp_regs #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.entries (entries),
		.timeout (timeout)
	);

	// sequencing: idle / collect / drain, output word valid
	cfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_kind   (item.cmd),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// match, counters, payload RAM and the output word register
	cfp_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_ARGS      (MAX_ARGS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (item.data_byte),
		.entries      (entries),
		.timeout      (timeout),
		.cmd          (cmd),
		.sts          (sts),
		.status       (result.status),
		.entry_index  (result.entry_index),
		.command_code (result.command_code),
		.payload_byte (result.payload_byte),
		.last         (result.last)
	);

endmodule

`default_nettype wire

// ===== rtl/cfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module cfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cfp_regs.sv =====
// APB register file: command table entries and timeout
`default_nettype none

module cfp_regs #(
	parameter int TABLE_ENTRIES = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [cfp_pkg::APB_AW-1:0]       paddr,
	input  wire logic [cfp_pkg::APB_DW-1:0]       pwdata,
	output logic      [cfp_pkg::APB_DW-1:0]       prdata,
	output logic                                  pready,
	output logic [TABLE_ENTRIES-1:0][cfp_pkg::ENTRY_W-1:0] entries,
	output logic      [cfp_pkg::TICK_W-1:0]       timeout
);

	logic [TABLE_ENTRIES-1:0][cfp_pkg::ENTRY_W-1:0] entry_q;
	logic [cfp_pkg::TICK_W-1:0]                     timeout_q;
	logic [2:0]                                     reg_idx;
	logic                                           wr_en;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q   <= '0;
			timeout_q <= cfp_pkg::TIMEOUT_RST;
		end else if (wr_en) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (reg_idx == cfp_pkg::REG_ENTRY_ZERO + 3'(i)) begin
					entry_q[i] <= pwdata[cfp_pkg::ENTRY_W-1:0];
				end
			end
			if (reg_idx == cfp_pkg::REG_TIMEOUT) begin
				timeout_q <= pwdata[cfp_pkg::TICK_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (reg_idx == cfp_pkg::REG_ENTRY_ZERO + 3'(i)) begin
				prdata = {{(cfp_pkg::APB_DW-cfp_pkg::ENTRY_W){1'b0}}, entry_q[i]};
			end
		end
		if (reg_idx == cfp_pkg::REG_TIMEOUT) begin
			prdata = {{(cfp_pkg::APB_DW-cfp_pkg::TICK_W){1'b0}}, timeout_q};
		end
	end

	assign entries = entry_q;
	assign timeout = timeout_q;

endmodule

`default_nettype wire

// ===== rtl/cfp_ctrl.sv =====
// Frame parser controller: state machine, output word valid, read pipeline
`default_nettype none
`include "command_frame_parser_core_defines.svh"

module cfp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_kind,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire cfp_pkg::cfp_sts_t sts,
	output cfp_pkg::cfp_cmd_t      cmd
);

	cfp_pkg::cfp_state_t state_q, state_nx;
	logic out_valid_q, out_valid_nx;
	logic rd_pend_q, rd_pend_nx;
	logic slot_free;
	logic in_fire;
	logic load_out;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cfp_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
		end else begin
			state_q     <= state_nx;
			out_valid_q <= out_valid_nx;
			rd_pend_q   <= rd_pend_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		cmd.out_sel = cfp_pkg::ST_PAYLOAD;
		in_ready = (state_q != cfp_pkg::S_DRAIN) && slot_free;
		in_fire  = in_valid && in_ready;
		load_out = 1'b0;
		rd_pend_nx = 1'b0;

		unique case (state_q)
			cfp_pkg::S_IDLE: begin
				if (in_fire && in_kind == cfp_pkg::CMD_BYTE) begin
					if (sts.hit && !sts.len_zero) begin
						cmd.latch_hdr = 1'b1;
						state_nx      = cfp_pkg::S_COLLECT;
					end else begin
						cmd.out_load = 1'b1;
						cmd.out_sel  = sts.hit ? cfp_pkg::ST_DONE : cfp_pkg::ST_UNKNOWN;
					end
				end
			end
			cfp_pkg::S_COLLECT: begin
				if (in_fire) begin
					unique case (in_kind)
						cfp_pkg::CMD_BYTE: begin
							cmd.store_byte = 1'b1;
							if (sts.rx_done) begin
								state_nx = cfp_pkg::S_DRAIN;
							end
						end
						cfp_pkg::CMD_TICK: begin
							cmd.tick = 1'b1;
							if (sts.tmo) begin
								cmd.out_load = 1'b1;
								cmd.out_sel  = cfp_pkg::ST_TIMEOUT;
								cmd.clear    = 1'b1;
								state_nx     = cfp_pkg::S_IDLE;
							end
						end
						default: ;
					endcase
				end
			end
			cfp_pkg::S_DRAIN: begin
				// RAM data of the pending read goes to the output word
				load_out     = rd_pend_q && slot_free;
				cmd.out_load = load_out;
				cmd.out_sel  = cfp_pkg::ST_PAYLOAD;
				cmd.rd_issue = sts.rd_more && (!rd_pend_q || load_out);
				rd_pend_nx   = cmd.rd_issue || (rd_pend_q && !load_out);
				if (load_out && !sts.rd_more) begin
					cmd.clear = 1'b1;
					state_nx  = cfp_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = cfp_pkg::S_IDLE;
			end
		endcase

		out_valid_nx = cmd.out_load || (out_valid_q && !out_ready);
	end

	assign out_valid = out_valid_q;

	`CFP_ASSERT_NOW(a_no_overwrite, cmd.out_load, slot_free, "output word overwritten")
	`CFP_ASSERT_NOW(a_pend_in_drain, rd_pend_q, state_q == cfp_pkg::S_DRAIN, "read pending outside drain")
	`CFP_ASSERT_NOW(a_drain_has_work, state_q == cfp_pkg::S_DRAIN && !rd_pend_q, sts.rd_more, "drain stalled with nothing to read")
	`CFP_ASSERT_NEXT(a_clear_to_idle, cmd.clear, state_q == cfp_pkg::S_IDLE, "clear did not return to idle")

endmodule

`default_nettype wire

// ===== rtl/cfp_dp.sv =====
// Frame parser datapath: table match, counters, payload store, output word
`default_nettype none

module cfp_dp #(
	parameter int TABLE_ENTRIES = 4,
	parameter int MAX_ARGS      = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [cfp_pkg::BYTE_W-1:0]  data_byte,
	input  wire logic [TABLE_ENTRIES-1:0][cfp_pkg::ENTRY_W-1:0] entries,
	input  wire logic [cfp_pkg::TICK_W-1:0]  timeout,
	input  wire cfp_pkg::cfp_cmd_t           cmd,
	output cfp_pkg::cfp_sts_t                sts,
	output logic [1:0]                       status,
	output logic [cfp_pkg::IDX_W-1:0]        entry_index,
	output logic [cfp_pkg::HDR_W-1:0]        command_code,
	output logic [cfp_pkg::BYTE_W-1:0]       payload_byte,
	output logic                             last
);

	localparam int CW = $clog2(MAX_ARGS + 1);
	localparam int AW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

	logic [cfp_pkg::HDR_W-1:0]  hdr_q;
	logic [cfp_pkg::IDX_W-1:0]  ent_q;
	logic [CW-1:0]              need_q;
	logic [CW-1:0]              rx_cnt_q;
	logic [CW-1:0]              rd_idx_q;
	logic [cfp_pkg::TICK_W-1:0] tick_q;
	logic [cfp_pkg::TICK_W-1:0] tick_nx;

	logic                       hit;
	logic [cfp_pkg::IDX_W-1:0]  hit_idx;
	logic [cfp_pkg::LEN_W-1:0]  hit_len;
	logic [CW-1:0]              len_clamp;
	logic [CW:0]                rx_next;
	logic [cfp_pkg::BYTE_W-1:0] ram_rd_data;

	logic [1:0]                 status_q;
	logic [cfp_pkg::IDX_W-1:0]  index_q;
	logic [cfp_pkg::HDR_W-1:0]  code_q;
	logic [cfp_pkg::BYTE_W-1:0] byte_q;
	logic                       last_q;

	// lowest-numbered valid match wins: scan down so entry 0 is written last
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		hit_len = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (entries[i][cfp_pkg::VALID_BIT] &&
					entries[i][cfp_pkg::HDR_W-1:0] == data_byte) begin
				hit     = 1'b1;
				hit_idx = cfp_pkg::IDX_W'(i);
				hit_len = entries[i][cfp_pkg::LEN_LSB +: cfp_pkg::LEN_W];
			end
		end
	end

	assign len_clamp = (hit_len > cfp_pkg::LEN_W'(MAX_ARGS)) ? CW'(MAX_ARGS) : hit_len[CW-1:0];
	assign rx_next   = {1'b0, rx_cnt_q} + (CW+1)'(1);
	assign tick_nx   = (tick_q == '1) ? tick_q : tick_q + cfp_pkg::TICK_W'(1);

	assign sts.hit      = hit;
	assign sts.len_zero = (hit_len == '0);
	assign sts.rx_done  = (rx_next >= {1'b0, need_q});
	assign sts.tmo      = (tick_nx > timeout);
	assign sts.rd_more  = (rd_idx_q < need_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= '0;
			ent_q    <= '0;
			need_q   <= '0;
			rx_cnt_q <= '0;
			rd_idx_q <= '0;
			tick_q   <= '0;
		end else if (cmd.clear) begin
			rx_cnt_q <= '0;
			rd_idx_q <= '0;
			tick_q   <= '0;
		end else begin
			if (cmd.latch_hdr) begin
				hdr_q    <= data_byte;
				ent_q    <= hit_idx;
				need_q   <= len_clamp;
				rx_cnt_q <= '0;
				rd_idx_q <= '0;
				tick_q   <= '0;
			end
			if (cmd.store_byte) begin
				rx_cnt_q <= rx_next[CW-1:0];
			end
			if (cmd.tick) begin
				tick_q <= tick_nx;
			end
			if (cmd.rd_issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
		end
	end

	cfp_ram #(
		.WIDTH (cfp_pkg::BYTE_W),
		.DEPTH (MAX_ARGS)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.store_byte),
		.wr_addr (rx_cnt_q[AW-1:0]),
		.wr_data (data_byte),
		.rd_en   (cmd.rd_issue),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (ram_rd_data)
	);

	// output word
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.out_sel;
			unique case (cmd.out_sel)
				cfp_pkg::ST_PAYLOAD: begin
					index_q <= ent_q;
					code_q  <= hdr_q;
					byte_q  <= ram_rd_data;
					last_q  <= !sts.rd_more;
				end
				cfp_pkg::ST_DONE: begin
					index_q <= hit_idx;
					code_q  <= data_byte;
					byte_q  <= '0;
					last_q  <= 1'b1;
				end
				cfp_pkg::ST_UNKNOWN: begin
					index_q <= '0;
					code_q  <= data_byte;
					byte_q  <= '0;
					last_q  <= 1'b1;
				end
				cfp_pkg::ST_TIMEOUT: begin
					index_q <= ent_q;
					code_q  <= hdr_q;
					byte_q  <= '0;
					last_q  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign status       = status_q;
	assign entry_index  = index_q;
	assign command_code = code_q;
	assign payload_byte = byte_q;
	assign last         = last_q;

endmodule

`default_nettype wire
